### rtl/kslp_pkg.sv
// Package for the short/long key press classifier.
// Holds key count, field widths, operation codes and the cell interface structs.
// No dependencies.
package kslp_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int MASK_KEYS = (NUM_KEYS < 4) ? NUM_KEYS : 4;  // keys visible in 4-bit masks

  localparam int FUNC_W  = 2;
  localparam int LEVEL_W = 4;
  localparam int INDEX_W = 2;
  localparam int COUNT_W = 16;

  localparam int IN_DATA_W  = 8;   // key_levels + key_index, padded to a byte
  localparam int OUT_DATA_W = 16;  // taken_event + three masks, padded

  localparam logic [COUNT_W-1:0] LONG_TICKS_RESET = 16'd1000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_TAKE_SHORT = 2'd1,
    FUNC_TAKE_LONG  = 2'd2,
    FUNC_CLEAR      = 2'd3
  } func_t;

  // Command broadcast to every key cell
  typedef struct packed {
    logic  fire;      // transaction leaves the input stage this cycle
    func_t func;
  } key_cmd_t;

  // Per-key state after the current transaction
  typedef struct packed {
    logic pressed;
    logic short_pend;
    logic long_pend;
    logic taken;      // pending flag returned by an addressed take
  } key_status_t;

endpackage

### rtl/kslp_key_cell.sv
// One key's press state: hold counter, consumed mark and pending flags.
// Depends on kslp_pkg.
module kslp_key_cell
  import kslp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  key_cmd_t           cmd,
  input  logic               level,      // debounced level for this key
  input  logic               sel,        // take addresses this key
  input  logic [COUNT_W-1:0] long_ticks,
  output key_status_t        status
);

  logic               pressed_r, pressed_nxt;
  logic               consumed_r, consumed_nxt;
  logic               short_r, short_nxt;
  logic               long_r, long_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W:0]   count_inc;
  logic               taken;

  assign count_inc = {1'b0, count_r} + {{COUNT_W{1'b0}}, 1'b1};

  always_comb begin
    pressed_nxt  = pressed_r;
    consumed_nxt = consumed_r;
    short_nxt    = short_r;
    long_nxt     = long_r;
    count_nxt    = count_r;
    taken        = 1'b0;
    unique case (cmd.func)
      FUNC_TICK: begin
        if (level) begin
          if (!pressed_r) begin
            pressed_nxt  = 1'b1;
            count_nxt    = '0;
            consumed_nxt = 1'b0;
          end else if (!consumed_r && (count_r < long_ticks)) begin
            count_nxt = count_inc[COUNT_W-1:0];
            if (count_inc >= {1'b0, long_ticks}) begin
              consumed_nxt = 1'b1;
              long_nxt     = 1'b1;
            end
          end
        end else if (pressed_r) begin
          pressed_nxt  = 1'b0;
          if (!consumed_r) short_nxt = 1'b1;
          count_nxt    = '0;
          consumed_nxt = 1'b0;
        end
      end
      FUNC_TAKE_SHORT: begin
        if (sel) begin
          taken     = short_r;
          short_nxt = 1'b0;
        end
      end
      FUNC_TAKE_LONG: begin
        if (sel) begin
          taken    = long_r;
          long_nxt = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        pressed_nxt  = 1'b0;
        consumed_nxt = 1'b0;
        short_nxt    = 1'b0;
        long_nxt     = 1'b0;
        count_nxt    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r  <= 1'b0;
      consumed_r <= 1'b0;
      short_r    <= 1'b0;
      long_r     <= 1'b0;
      count_r    <= '0;
    end else if (cmd.fire) begin
      pressed_r  <= pressed_nxt;
      consumed_r <= consumed_nxt;
      short_r    <= short_nxt;
      long_r     <= long_nxt;
      count_r    <= count_nxt;
    end
  end

  assign status = '{pressed: pressed_nxt, short_pend: short_nxt,
                    long_pend: long_nxt, taken: taken};

endmodule

### rtl/key_short_long_press_classifier.sv
// Top level of the short/long key press classifier.
// Depends on kslp_pkg and kslp_key_cell.
//
// Usage:
//   in_*   stream channel: one transaction per operation. in_tuser carries the
//          operation (tick, take short, take long, clear); in_tdata carries the
//          key levels (used on tick) and the key index (used on take).
//   out_*  stream channel: exactly one result per input transaction, in order:
//          the taken flag and the pressed / short-pending / long-pending masks
//          as they stand after that operation.
//   cfg_*  write channel for long_press_ticks; always ready. Write it only while
//          the block is idle.
// Path: input register, then per-key update logic into the result register.
// Throughput: one transaction per cycle while the output is not stalled; each
//   key cell computes its next counter and flags combinationally, so the state
//   feedback loop closes every cycle.
// Stall: when out_tready is low the result register holds, the input register
//   keeps its transaction, and in_tready drops once both are full.
// Reset: synchronous, active low. All key state clears, long_press_ticks
//   returns to 1000, both stages empty.
module key_short_long_press_classifier
  import kslp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] key_levels, [5:4] key_index, [7:6] zero
  input  logic [FUNC_W-1:0]     in_tuser,   // [1:0] func

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] taken_event, [4:1] down_mask,
                                            // [8:5] short_pending_mask,
                                            // [12:9] long_pending_mask, [15:13] zero

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data    // long_press_ticks
);

  // ---------------- configuration ----------------
  logic [COUNT_W-1:0] long_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      long_ticks_r <= cfg_data;
    end
  end

  // ---------------- input register ----------------
  logic               s1_valid_r;
  func_t              s1_func_r;
  logic [LEVEL_W-1:0] s1_levels_r;
  logic [INDEX_W-1:0] s1_index_r;
  logic               out_valid_r;
  logic               advance;   // input stage may move into the result register
  logic               fire;      // a transaction is processed this cycle

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r   <= func_t'(in_tuser);
      s1_levels_r <= in_tdata[LEVEL_W-1:0];
      s1_index_r  <= in_tdata[LEVEL_W +: INDEX_W];
    end
  end

  // ---------------- key cells ----------------
  key_cmd_t    cmd;
  key_status_t status [NUM_KEYS];

  assign cmd = '{fire: fire, func: s1_func_r};

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic level;
    logic sel;
    // keys past the level field always see a released level; keys past the
    // index range can never be addressed by a take
    if (k < LEVEL_W) begin : g_lvl
      assign level = s1_levels_r[k];
    end else begin : g_nolvl
      assign level = 1'b0;
    end
    if (k < (1 << INDEX_W)) begin : g_idx
      assign sel = (s1_index_r == INDEX_W'(k));
    end else begin : g_noidx
      assign sel = 1'b0;
    end

    kslp_key_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .level      (level),
      .sel        (sel),
      .long_ticks (long_ticks_r),
      .status     (status[k])
    );
  end

  // ---------------- result assembly ----------------
  logic       taken_any;
  logic [3:0] down_m, short_m, long_m;

  always_comb begin
    taken_any = 1'b0;
    down_m    = '0;
    short_m   = '0;
    long_m    = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      taken_any = taken_any | status[k].taken;
    end
    for (int k = 0; k < MASK_KEYS; k++) begin
      down_m[k]  = status[k].pressed;
      short_m[k] = status[k].short_pend;
      long_m[k]  = status[k].long_pend;
    end
  end

  // ---------------- result register ----------------
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {3'b000, long_m, short_m, down_m, taken_any};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/tb_key_short_long_press_classifier.sv
// Self-checking testbench for key_short_long_press_classifier.
// Streams key operations through a queue-fed driver and checks every result.
// Depends on kslp_pkg and the RTL of the classifier.
module tb_key_short_long_press_classifier;
  import kslp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 6;
  localparam int PHASE_OPS   = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_MSGS    = 50;

  // One operation on the input stream, and the report it should produce
  typedef struct packed {
    func_t                func;
    logic [LEVEL_W-1:0]   levels;
    logic [INDEX_W-1:0]   idx;
  } key_op_t;

  typedef struct packed {
    logic                 taken;
    logic [3:0]           down;
    logic [3:0]           short_p;
    logic [3:0]           long_p;
  } key_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [3:0] key_levels, [5:4] key_index, [7:6] zero
  logic [FUNC_W-1:0]     in_tuser = '0;   // [1:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [0] taken, [4:1] down, [8:5] short, [12:9] long
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data = '0;

  key_short_long_press_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Pending operations for the driver, expected reports for the monitor
  key_op_t     op_q[$];
  key_report_t report_q[$];

  // Shadow of the key state and the long-press limit
  logic [COUNT_W-1:0] mdl_limit;
  logic               mdl_pressed[NUM_KEYS];
  logic [COUNT_W-1:0] mdl_count[NUM_KEYS];
  logic               mdl_consumed[NUM_KEYS];
  logic               mdl_short[NUM_KEYS];
  logic               mdl_long[NUM_KEYS];

  int  n_err = 0;
  int  n_ops = 0;
  int  n_reports = 0;
  int  n_taken = 0;
  int  n_limits = 1;
  int  cycles = 0;
  bit  idling_on = 1'b1;
  logic in_took = 1'b0;   // input transaction completed at the last rising edge
  int  src_gap = 0;
  int  sink_gap = 0;

  // Random level generator: each key holds its level for a random run of ticks
  logic [LEVEL_W-1:0] held = '0;
  int                 run_left[LEVEL_W];

  function automatic void clear_keys();
    for (int k = 0; k < NUM_KEYS; k++) begin
      mdl_pressed[k]  = 1'b0;
      mdl_count[k]    = '0;
      mdl_consumed[k] = 1'b0;
      mdl_short[k]    = 1'b0;
      mdl_long[k]     = 1'b0;
    end
  endfunction

  // Advance the shadow state by one operation and return the report it yields
  function automatic key_report_t apply_op(key_op_t op);
    key_report_t r;
    logic        lv;
    r = '0;
    case (op.func)
      FUNC_TICK: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          lv = (k < LEVEL_W) ? op.levels[k] : 1'b0;
          if (lv) begin
            if (!mdl_pressed[k]) begin
              // first active tick only opens the press
              mdl_pressed[k]  = 1'b1;
              mdl_count[k]    = '0;
              mdl_consumed[k] = 1'b0;
            end else if (!mdl_consumed[k] && mdl_count[k] < mdl_limit) begin
              mdl_count[k] = mdl_count[k] + 1'b1;
              if (mdl_count[k] >= mdl_limit) begin
                mdl_consumed[k] = 1'b1;
                mdl_long[k]     = 1'b1;
              end
            end
          end else if (mdl_pressed[k]) begin
            mdl_pressed[k] = 1'b0;
            if (!mdl_consumed[k]) mdl_short[k] = 1'b1;
            mdl_count[k]    = '0;
            mdl_consumed[k] = 1'b0;
          end
        end
      end
      FUNC_TAKE_SHORT: begin
        if (int'(op.idx) < NUM_KEYS) begin
          r.taken = mdl_short[op.idx];
          mdl_short[op.idx] = 1'b0;
        end
      end
      FUNC_TAKE_LONG: begin
        if (int'(op.idx) < NUM_KEYS) begin
          r.taken = mdl_long[op.idx];
          mdl_long[op.idx] = 1'b0;
        end
      end
      default: clear_keys();
    endcase
    for (int k = 0; k < MASK_KEYS; k++) begin
      r.down[k]    = mdl_pressed[k];
      r.short_p[k] = mdl_short[k];
      r.long_p[k]  = mdl_long[k];
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      n_err++;
      if (n_err <= MAX_MSGS)
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Driver: presents queued operations, with random gaps between transactions while idling is on
  always @(negedge clk) begin
    logic    nv;
    key_op_t op;
    nv = in_tvalid;
    if (in_took) nv = 1'b0;
    if (!nv && rst_n) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (op_q.size() > 0) begin
        op = op_q.pop_front();
        in_tuser <= op.func;
        in_tdata <= {2'b00, op.idx, op.levels};
        nv = 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
      end
    end
    in_tvalid <= nv;
  end

  // Receiver: backpressure in random bursts while idling is on, else always ready
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!idling_on) begin
      out_tready <= 1'b1;
      sink_gap = 0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 5);
    end
  end

  // Monitor: checks results against the oldest expectation, then predicts new ones
  always @(posedge clk) begin
    key_report_t exp_r;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_reports++;
        if (report_q.size() == 0) begin
          n_err++;
          if (n_err <= MAX_MSGS)
            $display("%0t: unexpected result, expected none actual 0x%0h", $time, out_tdata);
        end else begin
          exp_r = report_q.pop_front();
          cmp_field("taken_event", exp_r.taken, out_tdata[0]);
          cmp_field("down_mask", exp_r.down, out_tdata[4:1]);
          cmp_field("short_pending_mask", exp_r.short_p, out_tdata[8:5]);
          cmp_field("long_pending_mask", exp_r.long_p, out_tdata[12:9]);
          cmp_field("tdata padding", 0, out_tdata[15:13]);
        end
      end
      if (in_tvalid && in_tready) begin
        n_ops++;
        exp_r = apply_op(key_op_t'{func_t'(in_tuser), in_tdata[3:0], in_tdata[5:4]});
        if (exp_r.taken) n_taken++;
        report_q.push_back(exp_r);
      end
      if (cfg_valid && cfg_ready) mdl_limit = cfg_data;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, report_q.size());
      $display("** key_short_long_press_classifier: FAILED **");
      $finish;
    end
  end

  task automatic push_op(func_t f, logic [LEVEL_W-1:0] lv, logic [INDEX_W-1:0] ix);
    op_q.push_back(key_op_t'{f, lv, ix});
  endtask

  // Sender holds off until the queue has drained and every result is back
  task automatic wait_idle();
    while (op_q.size() != 0 || in_tvalid || report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [COUNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  // Mostly held-level tick streams whose runs straddle limits up to 20, plus
  // takes, occasional clears and a few ticks with random levels
  task automatic fill_random(int n, int unsigned lim);
    int      cap;
    int      r;
    key_op_t op;
    cap = (lim == 0 || lim > 20) ? 12 : 2 * lim + 3;
    repeat (n) begin
      r = $urandom_range(0, 99);
      op.idx    = INDEX_W'($urandom_range(0, 3));
      op.levels = LEVEL_W'($urandom_range(0, 15));
      if (r < 65) begin
        for (int k = 0; k < LEVEL_W; k++) begin
          if (run_left[k] == 0) begin
            held[k]     = ~held[k];
            run_left[k] = $urandom_range(0, cap);
          end else begin
            run_left[k]--;
          end
        end
        op.func   = FUNC_TICK;
        op.levels = held;
      end else if (r < 92) begin
        op.func = func_t'($urandom_range(1, 2));
      end else if (r < 95) begin
        op.func = FUNC_CLEAR;
      end else begin
        op.func = FUNC_TICK;
      end
      op_q.push_back(op);
    end
  endtask

  initial begin
    int unsigned limits[$];
    mdl_limit = LONG_TICKS_RESET;
    clear_keys();
    for (int k = 0; k < LEVEL_W; k++) run_left[k] = 0;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset limit: press all keys, release for shorts, take each,
    // empty takes, and clear both while held and with flags pending
    push_op(FUNC_TICK, 4'hF, 2'd0);        // first active tick only starts the press
    push_op(FUNC_TICK, 4'hF, 2'd3);
    push_op(FUNC_TICK, 4'h0, 2'd0);        // release, short on every key
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd0);
    push_op(FUNC_TAKE_SHORT, 4'hF, 2'd1);
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd2);
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd3);
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd0);  // already taken
    push_op(FUNC_TAKE_LONG, 4'h0, 2'd3);
    push_op(FUNC_TICK, 4'h5, 2'd0);
    push_op(FUNC_CLEAR, 4'hF, 2'd3);       // clear while keys are down
    push_op(FUNC_TICK, 4'hA, 2'd0);
    push_op(FUNC_TICK, 4'h0, 2'd0);
    push_op(FUNC_CLEAR, 4'h0, 2'd0);       // clear with shorts pending
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd1);
    wait_idle();

    // Limit of one: the second held tick is already long
    write_limit(16'd1);
    push_op(FUNC_TICK, 4'h1, 2'd0);
    push_op(FUNC_TICK, 4'h1, 2'd0);
    push_op(FUNC_TICK, 4'h1, 2'd0);        // consumed, count stays bounded
    push_op(FUNC_TICK, 4'h0, 2'd0);        // release after long, no short
    push_op(FUNC_TAKE_LONG, 4'h0, 2'd0);
    push_op(FUNC_TAKE_LONG, 4'h0, 2'd0);
    wait_idle();

    // Limit of zero: never long, the release reports short
    write_limit(16'd0);
    push_op(FUNC_TICK, 4'h2, 2'd0);
    push_op(FUNC_TICK, 4'h2, 2'd0);
    push_op(FUNC_TICK, 4'h0, 2'd0);
    push_op(FUNC_TAKE_SHORT, 4'h0, 2'd1);
    wait_idle();

    // Random phases, first at the reset-value limit, written back explicitly
    write_limit(LONG_TICKS_RESET);
    fill_random(PHASE_OPS, LONG_TICKS_RESET);
    wait_idle();

    limits = '{1, 0, 65535, 2, 3, $urandom_range(4, 12), 5, $urandom_range(1, 20)};
    foreach (limits[p]) begin
      write_limit(COUNT_W'(limits[p]));
      if (p == limits.size() - 1) idling_on = 1'b0;   // full rate at the end
      fill_random(PHASE_OPS, limits[p]);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Ran %0d operations over %0d long-press limits (0, 1 and 65535 included),",
             n_ops, n_limits);
    $display("checked %0d results, %0d takes returned a pending press.", n_reports, n_taken);
    if (n_err == 0 && report_q.size() == 0) begin
      $display("** key_short_long_press_classifier: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_err, report_q.size());
      $display("** key_short_long_press_classifier: FAILED **");
    end
    $finish;
  end

endmodule
